FILE: design/plob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plob_pkg
// shared constants and controller/datapath handshake structs for the book core
// ----------------------------------------------------------------------------
package plob_pkg;

  localparam int unsigned PRICE_LEVELS = 4096;
  localparam int unsigned IDX_W        = $clog2(PRICE_LEVELS);
  localparam int unsigned LVL_W        = 13;
  localparam int unsigned PRICE_W      = 20;
  localparam int unsigned VOL_W        = 32;
  localparam int unsigned IMB_W        = 16;
  localparam int unsigned DIV_STEPS    = 16;
  localparam int unsigned DCNT_W       = 5;

  localparam logic [LVL_W-1:0] NO_ASK = LVL_W'(PRICE_LEVELS);
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(PRICE_LEVELS - 1);

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_REM = 1'b1;
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef struct packed {
    logic clr;        // write zero at clear counter
    logic latch;      // capture input item
    logic lvl_rd;     // read addressed level
    logic upd;        // write new level volume, move best
    logic scan_rd;    // read level at scan cursor
    logic scan_step;  // step cursor if level empty
    logic top_rd;     // read both best levels
    logic sizes;      // capture sizes, set up divide
    logic div_step;   // one quotient bit
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic oor;
    logic scan_more;
    logic scan_done;
    logic need_div;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/plob_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plob_ctrl
// sequencer for clear pass, level update, best-level scan and divide
// ----------------------------------------------------------------------------
module plob_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire plob_pkg::sts_t sts,
  output plob_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               out_valid
);
  import plob_pkg::*;

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_LVL_RD   = 4'd2;
  localparam logic [3:0] S_UPD      = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CHK = 4'd5;
  localparam logic [3:0] S_TOP_RD   = 4'd6;
  localparam logic [3:0] S_SIZES    = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_OUT      = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_LVL_RD;
        end
      end
      S_LVL_RD: begin
        cmd.lvl_rd = 1'b1;
        state_nxt  = sts.oor ? S_TOP_RD : S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.scan_more ? S_SCAN_RD : S_TOP_RD;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_step = 1'b1;
        state_nxt     = sts.scan_done ? S_TOP_RD : S_SCAN_RD;
      end
      S_TOP_RD: begin
        cmd.top_rd = 1'b1;
        state_nxt  = S_SIZES;
      end
      S_SIZES: begin
        cmd.sizes = 1'b1;
        state_nxt = sts.need_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule
`default_nettype wire

FILE: design/plob_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plob_dp
// level memories, best-level registers and restoring q15 divider
// ----------------------------------------------------------------------------
module plob_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire plob_pkg::cmd_t                 cmd,
  output plob_pkg::sts_t                      sts,
  input  wire logic                           in_func,
  input  wire logic                           in_side,
  input  wire logic [plob_pkg::PRICE_W-1:0]   in_price,
  input  wire logic [plob_pkg::VOL_W-1:0]     in_shares,
  output logic      [plob_pkg::LVL_W-1:0]     out_best_bid,
  output logic      [plob_pkg::LVL_W-1:0]     out_best_ask,
  output logic      [plob_pkg::VOL_W-1:0]     out_bid_size,
  output logic      [plob_pkg::VOL_W-1:0]     out_ask_size,
  output logic signed [plob_pkg::IMB_W-1:0]   out_imbalance,
  output logic                                out_ignored
);
  import plob_pkg::*;

  logic [VOL_W-1:0] bid_mem [PRICE_LEVELS];
  logic [VOL_W-1:0] ask_mem [PRICE_LEVELS];

  logic               func_r, side_r, oor_r;
  logic [IDX_W-1:0]   price_r;
  logic [VOL_W-1:0]   shares_r;
  logic [LVL_W-1:0]   top_bid_r, top_bid_nxt, top_ask_r, top_ask_nxt;
  logic [IDX_W-1:0]   clr_cnt_r;
  logic [VOL_W-1:0]   bid_rd_r, ask_rd_r;
  logic [VOL_W-1:0]   bsize_r, asize_r;
  logic [VOL_W:0]     sum_r;
  logic [VOL_W+1:0]   rem_r;
  logic [IMB_W-1:0]   quo_r;
  logic               neg_r;
  logic [DCNT_W-1:0]  dcnt_r;

  logic [IDX_W-1:0]   bid_ra, ask_ra, wr_a;
  logic               bid_we, ask_we;
  logic [VOL_W-1:0]   wr_d, lvl_v, new_v;
  logic [VOL_W:0]     add_full;
  logic [LVL_W-1:0]   price_l;
  logic               bid_ok, ask_ok;
  logic [VOL_W:0]     sum_c;
  logic [VOL_W+1:0]   rem_sub;
  logic               rem_ge;

  assign price_l = {1'b0, price_r};
  assign lvl_v   = side_r ? ask_rd_r : bid_rd_r;
  assign add_full = {1'b0, lvl_v} + {1'b0, shares_r};

  always_comb begin
    if (func_r == FUNC_ADD) begin
      new_v = add_full[VOL_W] ? {VOL_W{1'b1}} : add_full[VOL_W-1:0];
    end else begin
      new_v = (lvl_v > shares_r) ? (lvl_v - shares_r) : '0;
    end
  end

  // memory addressing
  always_comb begin
    bid_ra = top_bid_r[IDX_W-1:0];
    ask_ra = top_ask_r[IDX_W-1:0];
    if (cmd.lvl_rd) begin
      bid_ra = price_r;
      ask_ra = price_r;
    end
    wr_a   = cmd.clr ? clr_cnt_r : price_r;
    wr_d   = cmd.clr ? '0 : new_v;
    bid_we = cmd.clr || (cmd.upd && side_r == SIDE_BID);
    ask_we = cmd.clr || (cmd.upd && side_r == SIDE_ASK);
  end

  always_ff @(posedge clk) begin
    if (bid_we) bid_mem[wr_a] <= wr_d;
    bid_rd_r <= bid_mem[bid_ra];
  end

  always_ff @(posedge clk) begin
    if (ask_we) ask_mem[wr_a] <= wr_d;
    ask_rd_r <= ask_mem[ask_ra];
  end

  // best-level tracking
  always_comb begin
    top_bid_nxt = top_bid_r;
    top_ask_nxt = top_ask_r;
    if (cmd.upd) begin
      if (side_r == SIDE_BID) begin
        if (func_r == FUNC_ADD) begin
          if (price_l > top_bid_r) top_bid_nxt = price_l;
        end else if (price_l == top_bid_r && new_v == '0 && price_r != '0) begin
          top_bid_nxt = price_l - LVL_W'(1);
        end
      end else begin
        if (func_r == FUNC_ADD) begin
          if (price_l < top_ask_r) top_ask_nxt = price_l;
        end else if (price_l == top_ask_r && new_v == '0) begin
          top_ask_nxt = price_l + LVL_W'(1);
        end
      end
    end else if (cmd.scan_step) begin
      if (side_r == SIDE_BID) begin
        if (bid_rd_r == '0) top_bid_nxt = top_bid_r - LVL_W'(1);
      end else begin
        if (ask_rd_r == '0) top_ask_nxt = top_ask_r + LVL_W'(1);
      end
    end
  end

  assign sts.clr_last  = (clr_cnt_r == TOP_LVL[IDX_W-1:0]);
  assign sts.oor       = oor_r;
  assign sts.scan_more = (side_r == SIDE_BID) ? (top_bid_nxt != top_bid_r && top_bid_nxt != '0
                                                 && func_r == FUNC_REM)
                                              : (top_ask_nxt != top_ask_r && top_ask_nxt != NO_ASK
                                                 && func_r == FUNC_REM);
  assign sts.scan_done = (side_r == SIDE_BID) ? (bid_rd_r != '0 || top_bid_r == LVL_W'(1))
                                              : (ask_rd_r != '0 || top_ask_r == TOP_LVL);

  // divider setup
  assign bid_ok = (top_bid_r != '0);
  assign ask_ok = (top_ask_r != NO_ASK);
  assign sum_c  = (bid_ok ? {1'b0, bid_rd_r} : '0) + (ask_ok ? {1'b0, ask_rd_r} : '0);
  assign sts.need_div = bid_ok && ask_ok && (sum_c != '0);
  assign sts.div_last = (dcnt_r == DCNT_W'(1));

  assign rem_ge  = (rem_r >= {1'b0, sum_r});
  assign rem_sub = rem_r - {1'b0, sum_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_bid_r <= '0;
      top_ask_r <= NO_ASK;
      clr_cnt_r <= '0;
      dcnt_r    <= '0;
    end else begin
      top_bid_r <= top_bid_nxt;
      top_ask_r <= top_ask_nxt;
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (cmd.sizes) dcnt_r <= DCNT_W'(DIV_STEPS);
      else if (cmd.div_step) dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r   <= in_func;
      side_r   <= in_side;
      price_r  <= in_price[IDX_W-1:0];
      shares_r <= in_shares;
      oor_r    <= (in_price[PRICE_W-1:IDX_W] != '0);
    end
    if (cmd.sizes) begin
      bsize_r <= bid_ok ? bid_rd_r : '0;
      asize_r <= ask_ok ? ask_rd_r : '0;
      sum_r   <= sum_c;
      neg_r   <= ask_rd_r > bid_rd_r;
      rem_r   <= (ask_rd_r > bid_rd_r) ? {2'b00, ask_rd_r - bid_rd_r}
                                        : {2'b00, bid_rd_r - ask_rd_r};
      quo_r   <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[IMB_W-2:0], rem_ge};
      rem_r <= rem_ge ? {rem_sub[VOL_W:0], 1'b0} : {rem_r[VOL_W:0], 1'b0};
    end
  end

  always_comb begin
    if (neg_r) begin
      out_imbalance = $signed(IMB_W'(0) - quo_r);
    end else if (quo_r[IMB_W-1]) begin
      out_imbalance = $signed({1'b0, {(IMB_W-1){1'b1}}});
    end else begin
      out_imbalance = $signed(quo_r);
    end
  end

  assign out_best_bid = top_bid_r;
  assign out_best_ask = top_ask_r;
  assign out_bid_size = bsize_r;
  assign out_ask_size = asize_r;
  assign out_ignored  = oor_r;

endmodule
`default_nettype wire

FILE: design/price_level_order_book_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// price_level_order_book_core
// bid/ask price-level book with top of book and q1.15 best-level imbalance
// ----------------------------------------------------------------------------
// sequence: latch, level read, update, then a read and check per level scanned
//   after a removal empties the best, then top read and size capture, then the
//   divide when both sides are present and their best-level volumes do not sum
//   to zero; an ignored price skips the update and the scan
// items: one at a time; the divider is radix-2 and each level memory has one
//   read port; reset: synchronous active-low rst_n, then a clearing pass over
//   both level memories with busy high; results are strobed and cannot stall
module price_level_order_book_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_func,
  input  wire logic                            in_side,
  input  wire logic [plob_pkg::PRICE_W-1:0]    in_price,
  input  wire logic [plob_pkg::VOL_W-1:0]      in_shares,
  output logic                                 out_valid,
  output logic      [plob_pkg::LVL_W-1:0]      out_best_bid,
  output logic      [plob_pkg::LVL_W-1:0]      out_best_ask,
  output logic      [plob_pkg::VOL_W-1:0]      out_bid_size,
  output logic      [plob_pkg::VOL_W-1:0]      out_ask_size,
  output logic signed [plob_pkg::IMB_W-1:0]    out_imbalance,
  output logic                                 out_ignored
);
  import plob_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clear pass, item steps, scan loop, divide loop
  plob_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath: level memories, best registers, divider; outputs hold in the
  // strobe cycle since nothing moves while the sequencer sits in its out state
  plob_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_func),
    .in_side       (in_side),
    .in_price      (in_price),
    .in_shares     (in_shares),
    .out_best_bid  (out_best_bid),
    .out_best_ask  (out_best_ask),
    .out_bid_size  (out_bid_size),
    .out_ask_size  (out_ask_size),
    .out_imbalance (out_imbalance),
    .out_ignored   (out_ignored)
  );

endmodule
`default_nettype wire
